[hdl/dtrp_pkg.sv]
`default_nettype none

package dtrp_pkg;

    localparam int unsigned HDR_BYTES         = 6;
    localparam int unsigned MAX_NUMERIC_BYTES = 4;

    localparam logic [2:0] HC_VALUE = 3'(HDR_BYTES);

    // datapoint type codes
    localparam logic [7:0] TYPE_BOOL   = 8'h01;
    localparam logic [7:0] TYPE_VALUE  = 8'h02;
    localparam logic [7:0] TYPE_ENUM   = 8'h04;
    localparam logic [7:0] TYPE_BITMAP = 8'h05;

    // result kinds
    localparam logic [1:0] KIND_PASS     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    // end status codes
    localparam logic [1:0] END_CLEAN   = 2'd0;
    localparam logic [1:0] END_PARTIAL = 2'd1;
    localparam logic [1:0] END_OVERRUN = 2'd2;

    // all results caused by one input byte, delivered in mask order
    typedef struct packed {
        logic        has_pass;
        logic        has_comp;
        logic        has_end;
        logic [7:0]  vbyte;
        logic [15:0] seq;
        logic [7:0]  id;
        logic [7:0]  typ;
        logic [15:0] len;
        logic [31:0] num;
        logic        nvalid;
        logic [1:0]  status;
        logic [2:0]  trail;
    } t_bundle;

endpackage

`default_nettype wire

[hdl/datapoint_tlv_record_parser_core.sv]
`default_nettype none
// Datapoint TLV record parser.
// Input channel: one payload byte per transaction (i_data_byte), with
// i_end_of_payload set on the final byte. Output channel: one result per
// transaction: value byte passthrough, record complete (header plus numeric
// value where type/length allow it), or payload end summary. o_last_result
// marks the final result caused by one input byte.
// Output: each result is registered in the current slot, via the held slot
// when that is busy. Throughput: a byte is taken every cycle as long as
// each byte yields at most one result and the receiver keeps up. A byte
// yields up to three results (passthrough, record complete, payload
// summary), and the output port moves one per cycle, so such a byte holds
// the output for each of its results in turn; a result-bearing byte taken
// meanwhile is parked in the held slot, which closes the input until the group ahead has fully left.
// Storage: one result group being delivered plus one held group; input
// ready drops only while the held slot is full.
// Receiver stall: results wait in place, parser state only moves on input
// transactions, nothing is dropped.
// Reset: synchronous, active low; parser returns to header byte 0 with all
// header registers cleared and both result slots empty.
module datapoint_tlv_record_parser_core
    import dtrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_payload,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_value_byte,
    output logic [15:0]      o_sequence_res,
    output logic [7:0]       o_point_id,
    output logic [7:0]       o_point_type,
    output logic [15:0]      o_point_length,
    output logic [31:0]      o_numeric_value,
    output logic             o_numeric_valid,
    output logic [1:0]       o_end_status,
    output logic [2:0]       o_trailing_count,
    output logic             o_last_result
);

    // parser state
    logic [2:0]  r_hc,  n_hc;
    logic [15:0] r_seq, n_seq;
    logic [7:0]  r_id,  n_id;
    logic [7:0]  r_typ, n_typ;
    logic [15:0] r_len, n_len;
    logic [15:0] r_rem, n_rem;
    logic [31:0] r_acc, n_acc;

    // result slots: current (being delivered) and held
    t_bundle r_cur, n_cur;
    t_bundle r_hold, n_hold;
    logic    r_hold_valid, n_hold_valid;

    t_bundle new_b;
    logic    in_fire;
    logic    out_fire;
    logic    cur_any;
    logic    cur_done;
    logic    cur_free;
    logic    new_any;
    logic    complete;
    logic    nvalid;

    assign in_fire  = i_in_valid && o_in_ready;
    assign cur_any  = r_cur.has_pass || r_cur.has_comp || r_cur.has_end;
    assign out_fire = o_out_valid && i_out_ready;
    assign cur_done = out_fire && o_last_result;
    assign cur_free = !cur_any || cur_done;
    assign o_in_ready = !r_hold_valid;
    assign new_any  = new_b.has_pass || new_b.has_comp || new_b.has_end;

    // single pass over one byte: header capture or value byte, then
    // completion and payload end
    always_comb begin
        n_hc  = r_hc;
        n_seq = r_seq;
        n_id  = r_id;
        n_typ = r_typ;
        n_len = r_len;
        n_rem = r_rem;
        n_acc = r_acc;
        complete = 1'b0;
        new_b = '0;

        if (r_hc < HC_VALUE) begin
            unique case (r_hc)
                3'd0: begin
                    n_seq = {i_data_byte, 8'h00};
                    n_acc = '0;
                end
                3'd1: n_seq = {r_seq[15:8], i_data_byte};
                3'd2: n_id  = i_data_byte;
                3'd3: n_typ = i_data_byte;
                3'd4: n_len = {i_data_byte, 8'h00};
                default: n_len = {r_len[15:8], i_data_byte};
            endcase
            n_hc = r_hc + 3'd1;
            if (n_hc == HC_VALUE) begin
                n_rem = n_len;
                n_acc = '0;
                complete = (n_len == 16'd0);
            end
        end else begin
            new_b.has_pass = 1'b1;
            new_b.vbyte    = i_data_byte;
            n_acc = {r_acc[23:0], i_data_byte};
            n_rem = r_rem - 16'd1;
            complete = (n_rem == 16'd0);
        end

        new_b.seq = n_seq;
        new_b.id  = n_id;
        new_b.typ = n_typ;
        new_b.len = n_len;

        nvalid = (((n_typ == TYPE_BOOL) || (n_typ == TYPE_ENUM)) && (n_len == 16'd1))
              || (((n_typ == TYPE_VALUE) || (n_typ == TYPE_BITMAP))
                  && (n_len != 16'd0) && (n_len <= 16'(MAX_NUMERIC_BYTES)));

        if (complete) begin
            new_b.has_comp = 1'b1;
            new_b.nvalid   = nvalid;
            new_b.num      = nvalid ? n_acc : 32'd0;
            n_hc  = '0;
            n_rem = '0;
            n_acc = '0;
        end

        if (i_end_of_payload) begin
            new_b.has_end = 1'b1;
            if (n_hc == HC_VALUE) begin
                new_b.status = END_OVERRUN;
            end else if (n_hc != 3'd0) begin
                new_b.status = END_PARTIAL;
                new_b.trail  = n_hc;
            end else begin
                new_b.status = END_CLEAN;
            end
            n_hc  = '0;
            n_seq = '0;
            n_id  = '0;
            n_typ = '0;
            n_len = '0;
            n_rem = '0;
            n_acc = '0;
        end
    end

    // slot movement
    always_comb begin
        n_cur        = r_cur;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;

        // retire the result just delivered, in order pass, complete, end
        if (out_fire) begin
            if (r_cur.has_pass) begin
                n_cur.has_pass = 1'b0;
            end else if (r_cur.has_comp) begin
                n_cur.has_comp = 1'b0;
            end else begin
                n_cur.has_end = 1'b0;
            end
        end

        if (cur_free) begin
            if (r_hold_valid) begin
                n_cur        = r_hold;
                n_hold_valid = 1'b0;
            end else if (in_fire && new_any) begin
                n_cur = new_b;
            end
        end else if (in_fire && new_any) begin
            n_hold       = new_b;
            n_hold_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc  <= '0;
            r_seq <= '0;
            r_id  <= '0;
            r_typ <= '0;
            r_len <= '0;
            r_rem <= '0;
            r_acc <= '0;
            r_cur.has_pass <= 1'b0;
            r_cur.has_comp <= 1'b0;
            r_cur.has_end  <= 1'b0;
            r_hold_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_hc  <= n_hc;
                r_seq <= n_seq;
                r_id  <= n_id;
                r_typ <= n_typ;
                r_len <= n_len;
                r_rem <= n_rem;
                r_acc <= n_acc;
            end
            r_cur        <= n_cur;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    // output mux over the current slot
    always_comb begin
        o_out_valid      = cur_any;
        o_result_kind    = KIND_END;
        o_value_byte     = '0;
        o_sequence_res   = '0;
        o_point_id       = '0;
        o_point_type     = '0;
        o_point_length   = '0;
        o_numeric_value  = '0;
        o_numeric_valid  = 1'b0;
        o_end_status     = r_cur.status;
        o_trailing_count = r_cur.trail;
        o_last_result    = 1'b1;
        if (r_cur.has_pass) begin
            o_result_kind    = KIND_PASS;
            o_value_byte     = r_cur.vbyte;
            o_end_status     = END_CLEAN;
            o_trailing_count = '0;
            o_last_result    = !(r_cur.has_comp || r_cur.has_end);
        end else if (r_cur.has_comp) begin
            o_result_kind    = KIND_COMPLETE;
            o_numeric_value  = r_cur.num;
            o_numeric_valid  = r_cur.nvalid;
            o_end_status     = END_CLEAN;
            o_trailing_count = '0;
            o_last_result    = !r_cur.has_end;
        end
        if (r_cur.has_pass || r_cur.has_comp) begin
            o_sequence_res = r_cur.seq;
            o_point_id     = r_cur.id;
            o_point_type   = r_cur.typ;
            o_point_length = r_cur.len;
        end
    end

    // held group only exists behind a busy current slot
    a_hold_behind_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> cur_any)
        else $error("held result group with empty current slot");

    // value phase always owes at least one byte
    a_value_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hc == HC_VALUE) |-> (r_rem != 16'd0))
        else $error("value phase with nothing remaining");

    // payload end returns the parser to its first header byte
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_end_of_payload) |=> (r_hc == 3'd0 && r_rem == 16'd0))
        else $error("parser state not cleared at payload end");

    a_hc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc <= HC_VALUE)
        else $error("header count out of range");

endmodule

`default_nettype wire

[test/datapoint_tlv_record_parser_checker.sv]
// Watches both channels of the record parser, predicts every result from the
// accepted bytes and compares the results in order.
module datapoint_tlv_record_parser_checker
    import dtrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_payload,

    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_result_kind,
    input  wire logic [7:0]  i_value_byte,
    input  wire logic [15:0] i_sequence_res,
    input  wire logic [7:0]  i_point_id,
    input  wire logic [7:0]  i_point_type,
    input  wire logic [15:0] i_point_length,
    input  wire logic [31:0] i_numeric_value,
    input  wire logic        i_numeric_valid,
    input  wire logic [1:0]  i_end_status,
    input  wire logic [2:0]  i_trailing_count,
    input  wire logic        i_last_result,

    output int               o_mismatch_count,
    output int               o_pending_count
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  vbyte;
        logic [15:0] seq;
        logic [7:0]  id;
        logic [7:0]  typ;
        logic [15:0] len;
        logic [31:0] num;
        logic        nvalid;
        logic [1:0]  status;
        logic [2:0]  trail;
        logic        last;
    } parse_result_t;

    // parser state mirror
    logic [2:0]  hdr_count;
    logic [15:0] rec_seq;
    logic [7:0]  rec_id;
    logic [7:0]  rec_type;
    logic [15:0] rec_len;
    logic [15:0] bytes_owed;
    logic [31:0] value_acc;

    parse_result_t expected_results[$];
    int            mismatches = 0;

    initial begin
        o_mismatch_count = 0;
        o_pending_count  = 0;
    end

    task automatic clear_parser();
        hdr_count  = '0;
        rec_seq    = '0;
        rec_id     = '0;
        rec_type   = '0;
        rec_len    = '0;
        bytes_owed = '0;
        value_acc  = '0;
    endtask

    function automatic parse_result_t header_result(input logic [1:0] kind);
        parse_result_t r;
        r       = '0;
        r.kind  = kind;
        r.seq   = rec_seq;
        r.id    = rec_id;
        r.typ   = rec_type;
        r.len   = rec_len;
        return r;
    endfunction

    // record complete result; closes the record
    function automatic parse_result_t close_record();
        parse_result_t r;
        logic          numeric;
        r       = header_result(KIND_COMPLETE);
        numeric = ((rec_type == TYPE_BOOL || rec_type == TYPE_ENUM) && rec_len == 16'd1) ||
                  ((rec_type == TYPE_VALUE || rec_type == TYPE_BITMAP) &&
                   rec_len >= 16'd1 && rec_len <= 16'(MAX_NUMERIC_BYTES));
        r.nvalid = numeric;
        r.num    = numeric ? value_acc : 32'd0;
        hdr_count  = '0;
        bytes_owed = '0;
        value_acc  = '0;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eop);
        parse_result_t group[$];
        parse_result_t r;
        if (hdr_count < HC_VALUE) begin
            case (hdr_count)
                3'd0: begin
                    rec_seq   = {b, 8'h00};
                    value_acc = '0;
                end
                3'd1: rec_seq[7:0] = b;
                3'd2: rec_id = b;
                3'd3: rec_type = b;
                3'd4: rec_len = {b, 8'h00};
                default: rec_len[7:0] = b;
            endcase
            hdr_count = hdr_count + 3'd1;
            if (hdr_count == HC_VALUE) begin
                bytes_owed = rec_len;
                value_acc  = '0;
                if (rec_len == 16'd0) group.push_back(close_record());
            end
        end else begin
            r       = header_result(KIND_PASS);
            r.vbyte = b;
            group.push_back(r);
            value_acc  = {value_acc[23:0], b};
            bytes_owed = bytes_owed - 16'd1;
            if (bytes_owed == 16'd0) group.push_back(close_record());
        end

        if (eop) begin
            r      = '0;
            r.kind = KIND_END;
            if (hdr_count >= HC_VALUE) begin
                // value bytes still owed: record voided
                r.status = END_OVERRUN;
            end else if (hdr_count != 3'd0) begin
                r.status = END_PARTIAL;
                r.trail  = hdr_count;
            end else begin
                r.status = END_CLEAN;
            end
            group.push_back(r);
            clear_parser();
        end

        if (group.size() > 0) group[group.size() - 1].last = 1'b1;
        foreach (group[i]) expected_results.push_back(group[i]);
    endtask

    task automatic show(input string tag, input parse_result_t r);
        $display("  %s kind=%0d byte=%h seq=%h id=%h type=%h len=%h num=%h nv=%b st=%0d tr=%0d last=%b",
                 tag, r.kind, r.vbyte, r.seq, r.id, r.typ, r.len, r.num, r.nvalid,
                 r.status, r.trail, r.last);
    endtask

    task automatic check_result();
        parse_result_t got;
        parse_result_t want;
        got = '{i_result_kind, i_value_byte, i_sequence_res, i_point_id, i_point_type,
                i_point_length, i_numeric_value, i_numeric_valid, i_end_status,
                i_trailing_count, i_last_result};
        if (expected_results.size() == 0) begin
            if (mismatches < 10) begin
                $display("unexpected result at %0t", $realtime);
                show("got ", got);
            end
            mismatches++;
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                if (mismatches < 10) begin
                    $display("result mismatch at %0t", $realtime);
                    show("want", want);
                    show("got ", got);
                end
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) parse_byte(i_data_byte, i_end_of_payload);
            if (i_out_valid && i_out_ready) check_result();
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= expected_results.size();
    end

endmodule

[test/datapoint_tlv_record_parser_core_test.sv]
// Top of the parser testbench: clock, reset, byte stream stimulus, output
// back-pressure and the final verdict. All prediction and comparison lives
// in the checker instantiated next to the block.
module datapoint_tlv_record_parser_core_test;
    import dtrp_pkg::*;

    localparam int DIRECTED_ITEMS = 31;
    localparam int RANDOM_ITEMS   = 340;
    localparam int CYCLE_LIMIT    = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_payload = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  value_byte;
    logic [15:0] sequence_res;
    logic [7:0]  point_id;
    logic [7:0]  point_type;
    logic [15:0] point_length;
    logic [31:0] numeric_value;
    logic        numeric_valid;
    logic [1:0]  end_status;
    logic [2:0]  trailing_count;
    logic        last_result;

    int          mismatch_count;
    int          pending_count;

    // percentages of cycles in which the sender / receiver hold off
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;

    int          items_sent = 0;
    int          cycle_count = 0;

    // bytes of the payload being assembled
    logic [7:0]  payload_bytes[$];

    datapoint_tlv_record_parser_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .i_end_of_payload (end_of_payload),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_kind    (result_kind),
        .o_value_byte     (value_byte),
        .o_sequence_res   (sequence_res),
        .o_point_id       (point_id),
        .o_point_type     (point_type),
        .o_point_length   (point_length),
        .o_numeric_value  (numeric_value),
        .o_numeric_valid  (numeric_valid),
        .o_end_status     (end_status),
        .o_trailing_count (trailing_count),
        .o_last_result    (last_result)
    );

    datapoint_tlv_record_parser_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .i_end_of_payload (end_of_payload),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_kind    (result_kind),
        .i_value_byte     (value_byte),
        .i_sequence_res   (sequence_res),
        .i_point_id       (point_id),
        .i_point_type     (point_type),
        .i_point_length   (point_length),
        .i_numeric_value  (numeric_value),
        .i_numeric_valid  (numeric_valid),
        .i_end_status     (end_status),
        .i_trailing_count (trailing_count),
        .i_last_result    (last_result),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver back-pressure: ready is redrawn every cycle.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // One input transaction. An optional idle gap drops valid first; otherwise
    // valid stays high straight into the next byte.
    task automatic send_byte(input logic [7:0] b, input logic eop);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        end_of_payload <= eop;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
    endtask

    // Ship the assembled payload, flagging its final byte.
    task automatic send_payload();
        int n;
        n = payload_bytes.size();
        for (int i = 0; i < n; i++) send_byte(payload_bytes[i], i == n - 1);
        payload_bytes.delete();
    endtask

    task automatic add_header(input logic [15:0] seq, input logic [7:0] id,
                              input logic [7:0] typ, input logic [15:0] len);
        payload_bytes.push_back(seq[15:8]);
        payload_bytes.push_back(seq[7:0]);
        payload_bytes.push_back(id);
        payload_bytes.push_back(typ);
        payload_bytes.push_back(len[15:8]);
        payload_bytes.push_back(len[7:0]);
    endtask

    // Header with random sequence/id, followed by len random value bytes.
    task automatic add_record(input logic [7:0] typ, input logic [15:0] len);
        add_header(16'($urandom), 8'($urandom), typ, len);
        for (int i = 0; i < len; i++) payload_bytes.push_back(8'($urandom));
    endtask

    // Stop feeding bytes until every predicted result has drained.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed chains of records with random content (numeric types
    // and short lengths favored), some cut short mid-header or mid-value,
    // and some plain noise whose length field usually overruns.
    task automatic random_payload();
        int          sel;
        int          n_rec;
        int          cut;
        int          p;
        logic [7:0]  typ;
        logic [15:0] len;
        sel   = $urandom_range(99);
        n_rec = $urandom_range(1, 3);
        for (int r = 0; r < n_rec; r++) begin
            p   = $urandom_range(99);
            typ = (p < 85) ? 8'($urandom_range(0, 5)) : 8'($urandom);
            p   = $urandom_range(99);
            if (p < 60)      len = 16'($urandom_range(0, 4));
            else if (p < 90) len = 16'($urandom_range(5, 10));
            else             len = 16'($urandom_range(11, 24));
            add_record(typ, len);
        end
        if (sel >= 90) begin
            payload_bytes.delete();
            p = $urandom_range(1, 12);
            for (int i = 0; i < p; i++) payload_bytes.push_back(8'($urandom));
        end else if (sel >= 70) begin
            cut = $urandom_range(1, payload_bytes.size() - 1);
            while (payload_bytes.size() > cut) void'(payload_bytes.pop_back());
        end
        send_payload();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, no idling. Bool record with all-ones sequence and id, then a
        // 4-byte value record whose final value byte also ends the payload
        // (passthrough, complete and summary from one byte).
        add_header(16'hFFFF, 8'hFF, TYPE_BOOL, 16'h0001);
        payload_bytes.push_back(8'hA5);
        add_header(16'h0000, 8'h00, TYPE_VALUE, 16'h0004);
        repeat (4) payload_bytes.push_back(8'hFF);
        send_payload();

        // Zero-length enum record, then a 2-byte partial header at payload end.
        add_header(16'h8001, 8'h7E, TYPE_ENUM, 16'h0000);
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'h00);
        send_payload();

        // Header completes on the final byte with a huge length: overrun.
        add_header(16'h1234, 8'h5A, 8'hFF, 16'hFFFF);
        send_payload();

        // Pressure: full drain before the random part.
        drain_results();

        // Random part in three phases: sender light / receiver heavy idling,
        // then swapped, then flat out. Drain between phases.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 12;
                    rx_stall_pct <= 59;
                end
                1: begin
                    tx_idle_pct = 59;
                    rx_stall_pct <= 12;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
            endcase
            while (items_sent < DIRECTED_ITEMS + (phase + 1) * RANDOM_ITEMS / 3)
                random_payload();
            drain_results();
        end

        // Catch any stray result past the last expected one.
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
